// ===== hdl/mcrp_pkg.sv =====
// Shared types and codes for the randomized Prim maze carver.
// No dependencies; used by every file under hdl.
package mcrp_pkg;

	localparam int COORD_W = 9;
	localparam int OUT_W = 11;
	localparam int RND_W = 16;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_PICK  = 2'd1,
		ACT_DIR   = 2'd2,
		ACT_READ  = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_REFUSED = 2'd1,
		ST_NA      = 2'd2
	} status_t;

	localparam logic [1:0] KIND_WALL  = 2'd0;
	localparam logic [1:0] KIND_HOLE  = 2'd1;
	localparam logic [1:0] KIND_FRONT = 2'd2;

	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_S = 2'd1;
	localparam logic [1:0] DIR_W = 2'd2;
	localparam logic [1:0] DIR_E = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_DIV,
		S_PICKRD,
		S_SHIFT,
		S_DIRCHK,
		S_MARK,
		S_NB,
		S_NBCHK,
		S_RDCHK,
		S_DONE
	} state_t;

endpackage

// ===== hdl/mcrp_mod.sv =====
// Iterative restoring remainder unit: one dividend bit per cycle.
// Depends on mcrp_pkg for the dividend width.
module mcrp_mod import mcrp_pkg::*; #(
	parameter int DW = 11
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [RND_W-1:0] dividend,
	input  logic [DW-1:0]   divisor,
	output logic            done,
	output logic [DW-1:0]   rem
);

	localparam int CNT_W = $clog2(RND_W + 1);

	logic [RND_W-1:0] num_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      trial;

	assign trial = {rem_q, num_q[RND_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(RND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[RND_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q})
				rem_q <= DW'(trial - {1'b0, den_q});
			else
				rem_q <= trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign rem = rem_q;

endmodule

// ===== hdl/maze_carver_random_prim.sv =====
// Top level of the randomized Prim maze carver: grid and frontier memories,
// sequencer and result register. Depends on mcrp_pkg and mcrp_mod.
//
// channel  | signals                          | role
// s_axis   | s_tvalid s_tready s_tdata[31:0]  | input items
// m_axis   | m_tvalid m_tready m_tdata[31:0]  | one result per item
// cfg      | cfg_valid cfg_ready cfg_index    | size registers
//          | cfg_data[6:0]                    |
//
// From acceptance to result load: a start item clears the grid, then marks the
// start cell and its frontier neighbours; a pick computes the random remainder,
// then moves each list entry above the chosen one down by one place.
// One item is in work at a time. After reset the grid is cleared before
// s_tready rises. A result waits in the output register while the next item
// is accepted; a second result holds the input.
module maze_carver_random_prim import mcrp_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int FRONTIER_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // action[1:0] row[7:2] col[13:8] random_value[29:14] direction[31:30]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // status[1:0] out_row[7:2] out_col[13:8] cell_kind[15:14]
	                               // frontiers_left[26:16] maze_done[27]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int AW = RW + CW;
	localparam int GRID_DEPTH = 1 << AW;
	localparam int FIW = $clog2(FRONTIER_DEPTH);
	localparam int FCW = $clog2(FRONTIER_DEPTH + 1);
	localparam int RST_ROWS = (63 > MAX_ROWS) ? MAX_ROWS : 63;
	localparam int RST_COLS = (63 > MAX_COLS) ? MAX_COLS : 63;

	logic [1:0]      grid_mem [0:GRID_DEPTH-1];
	logic [AW-1:0]   fl_mem [0:FRONTIER_DEPTH-1];

	state_t              state_q, state_d;
	act_t                act_q;
	logic [6:0]          rows_cfg_q, cols_cfg_q;
	logic [COORD_W-1:0]  ur_q, uc_q, mr_q, mc_q, pr_q, pc_q;
	logic                pv_q;
	logic [FCW-1:0]      cnt_q, sh_q;
	logic                sh_v_s1;
	logic [FIW-1:0]      sh_a_s1;
	logic [1:0]          nb_q, dir_q;
	logic [AW-1:0]       clr_q;
	logic [1:0]          gr_q;
	logic [AW-1:0]       fl_rd_q;
	status_t             res_status_q;
	logic [COORD_W-1:0]  res_row_q, res_col_q;
	logic [1:0]          res_kind_q;
	logic                out_v_q;
	logic [31:0]         out_q;

	logic                gw_en, fl_we, load_out;
	logic [AW-1:0]       gw_addr, gr_addr, fl_wdata;
	logic [1:0]          gw_data;
	logic [FIW-1:0]      fl_waddr, fl_raddr;
	logic                div_start, div_done;
	logic [FCW-1:0]      div_rem;

	act_t                in_act;
	logic [COORD_W-1:0]  in_row, in_col, cl_r, cl_c, od_r, od_c;
	logic [RND_W-1:0]    in_rnd;
	logic [1:0]          in_dir;
	logic [COORD_W-1:0]  nr, nc, tr, tc, br, bc;
	logic                nb_ok, dir_ok, in_area;
	logic [31:0]         cnt32, rr32, rc32;

	function automatic logic [COORD_W-1:0] clamp_dim(input logic [6:0] v, input int maxv);
		logic [COORD_W-1:0] w;
		w = COORD_W'(v);
		if (w < COORD_W'(5)) return COORD_W'(5);
		if (w > COORD_W'(maxv)) return COORD_W'(maxv);
		return w;
	endfunction

	function automatic logic [COORD_W-1:0] odd_inside(input logic [COORD_W-1:0] v,
			input logic [COORD_W-1:0] dim);
		logic [COORD_W-1:0] lim, o;
		lim = dim - COORD_W'(2);
		o = v | COORD_W'(1);
		if (o > lim) o = lim[0] ? lim : lim - COORD_W'(1);
		return o;
	endfunction

	assign in_act = act_t'(s_tdata[1:0]);
	assign in_row = COORD_W'(s_tdata[7:2]);
	assign in_col = COORD_W'(s_tdata[13:8]);
	assign in_rnd = s_tdata[29:14];
	assign in_dir = s_tdata[31:30];
	assign cl_r = clamp_dim(rows_cfg_q, MAX_ROWS);
	assign cl_c = clamp_dim(cols_cfg_q, MAX_COLS);
	assign od_r = odd_inside(in_row, cl_r);
	assign od_c = odd_inside(in_col, cl_c);
	assign in_area = (in_row < ur_q) && (in_col < uc_q);

	assign s_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	always_comb begin
		nr = mr_q;
		nc = mc_q;
		nb_ok = 1'b0;
		unique case (nb_q)
			DIR_N: begin nb_ok = mr_q >= COORD_W'(3); nr = mr_q - COORD_W'(2); end
			DIR_S: begin nb_ok = mr_q + COORD_W'(2) <= ur_q - COORD_W'(2); nr = mr_q + COORD_W'(2); end
			DIR_W: begin nb_ok = mc_q >= COORD_W'(3); nc = mc_q - COORD_W'(2); end
			default: begin nb_ok = mc_q + COORD_W'(2) <= uc_q - COORD_W'(2); nc = mc_q + COORD_W'(2); end
		endcase
	end

	always_comb begin
		tr = pr_q; tc = pc_q; br = pr_q; bc = pc_q;
		dir_ok = 1'b0;
		unique case (state_q == S_IDLE ? in_dir : dir_q)
			DIR_N: begin
				dir_ok = pr_q > COORD_W'(2);
				tr = pr_q - COORD_W'(2); br = pr_q - COORD_W'(1);
			end
			DIR_S: begin
				dir_ok = pr_q + COORD_W'(2) < ur_q - COORD_W'(1);
				tr = pr_q + COORD_W'(2); br = pr_q + COORD_W'(1);
			end
			DIR_W: begin
				dir_ok = pc_q > COORD_W'(2);
				tc = pc_q - COORD_W'(2); bc = pc_q - COORD_W'(1);
			end
			default: begin
				dir_ok = pc_q + COORD_W'(2) < uc_q - COORD_W'(1);
				tc = pc_q + COORD_W'(2); bc = pc_q + COORD_W'(1);
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		gw_en = 1'b0;
		gw_addr = {mr_q[RW-1:0], mc_q[CW-1:0]};
		gw_data = KIND_HOLE;
		gr_addr = {nr[RW-1:0], nc[CW-1:0]};
		fl_we = 1'b0;
		fl_waddr = cnt_q[FIW-1:0];
		fl_wdata = {nr[RW-1:0], nc[CW-1:0]};
		fl_raddr = sh_q[FIW-1:0];
		div_start = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					unique case (in_act)
						ACT_START: state_d = S_CLEAR;
						ACT_PICK: begin
							if (pv_q || cnt_q == '0) state_d = S_DONE;
							else begin
								div_start = 1'b1;
								state_d = S_DIV;
							end
						end
						ACT_DIR: begin
							gr_addr = {tr[RW-1:0], tc[CW-1:0]};
							if (pv_q && dir_ok) state_d = S_DIRCHK;
							else state_d = S_DONE;
						end
						default: begin
							gr_addr = {in_row[RW-1:0], in_col[CW-1:0]};
							state_d = in_area ? S_RDCHK : S_DONE;
						end
					endcase
				end
			end
			S_CLEAR: begin
				gw_en = 1'b1;
				gw_addr = clr_q;
				gw_data = KIND_WALL;
				if (&clr_q) state_d = (act_q == ACT_START) ? S_MARK : S_IDLE;
			end
			S_DIV: begin
				fl_raddr = div_rem[FIW-1:0];
				if (div_done) state_d = S_PICKRD;
			end
			S_PICKRD: state_d = S_SHIFT;
			S_SHIFT: begin
				fl_we = sh_v_s1;
				fl_waddr = sh_a_s1;
				fl_wdata = fl_rd_q;
				if (!(sh_q < cnt_q) && !sh_v_s1) state_d = S_DONE;
			end
			S_DIRCHK: begin
				if (gr_q == KIND_HOLE) begin
					gw_en = 1'b1;
					gw_addr = {br[RW-1:0], bc[CW-1:0]};
					state_d = S_MARK;
				end else state_d = S_DONE;
			end
			S_MARK: begin
				gw_en = 1'b1;
				state_d = S_NB;
			end
			S_NB: begin
				if (nb_ok) state_d = S_NBCHK;
				else if (nb_q == DIR_E) state_d = S_DONE;
			end
			S_NBCHK: begin
				if (gr_q == KIND_WALL && cnt_q < FCW'(FRONTIER_DEPTH)) begin
					gw_en = 1'b1;
					gw_addr = {nr[RW-1:0], nc[CW-1:0]};
					gw_data = KIND_FRONT;
					fl_we = 1'b1;
				end
				state_d = (nb_q == DIR_E) ? S_DONE : S_NB;
			end
			S_RDCHK: state_d = S_DONE;
			S_DONE: begin
				if (!out_v_q || m_tready) begin
					load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (gw_en) grid_mem[gw_addr] <= gw_data;
		gr_q <= grid_mem[gr_addr];
		if (fl_we) fl_mem[fl_waddr] <= fl_wdata;
		fl_rd_q <= fl_mem[fl_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= 7'd63;
			cols_cfg_q <= 7'd63;
		end else if (cfg_valid) begin
			if (cfg_index) cols_cfg_q <= cfg_data;
			else rows_cfg_q <= cfg_data;
		end
	end

	assign cnt32 = 32'(cnt_q);
	assign rr32 = 32'(res_row_q);
	assign rc32 = 32'(res_col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACT_READ;
			ur_q <= COORD_W'(RST_ROWS);
			uc_q <= COORD_W'(RST_COLS);
			cnt_q <= '0;
			pv_q <= 1'b0;
			pr_q <= '0;
			pc_q <= '0;
			clr_q <= '0;
			nb_q <= '0;
			sh_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load_out) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						act_q <= in_act;
						if (in_act == ACT_START) begin
							ur_q <= cl_r;
							uc_q <= cl_c;
							cnt_q <= '0;
							pv_q <= 1'b0;
							pr_q <= '0;
							pc_q <= '0;
							clr_q <= '0;
						end
					end
				end
				S_PICKRD: begin
					pr_q <= COORD_W'(fl_rd_q[AW-1:CW]);
					pc_q <= COORD_W'(fl_rd_q[CW-1:0]);
					sh_v_s1 <= 1'b0;
				end
				S_SHIFT: begin
					sh_v_s1 <= sh_q < cnt_q;
					if (!(sh_q < cnt_q) && !sh_v_s1) begin
						cnt_q <= cnt_q - 1'b1;
						pv_q <= 1'b1;
					end
				end
				S_DIRCHK: if (gr_q == KIND_HOLE) pv_q <= 1'b0;
				S_MARK: nb_q <= '0;
				S_NB: if (!nb_ok) nb_q <= nb_q + 1'b1;
				S_NBCHK: begin
					nb_q <= nb_q + 1'b1;
					if (gr_q == KIND_WALL && cnt_q < FCW'(FRONTIER_DEPTH)) cnt_q <= cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					dir_q <= in_dir;
					res_kind_q <= KIND_WALL;
					unique case (in_act)
						ACT_START: begin
							mr_q <= od_r;
							mc_q <= od_c;
							res_status_q <= ST_OK;
							res_row_q <= od_r;
							res_col_q <= od_c;
						end
						ACT_PICK: begin
							res_status_q <= (pv_q || cnt_q == '0) ? ST_NA : ST_OK;
							res_row_q <= '0;
							res_col_q <= '0;
						end
						ACT_DIR: begin
							res_status_q <= !pv_q ? ST_NA : (!dir_ok ? ST_REFUSED : ST_OK);
							res_row_q <= pv_q ? pr_q : '0;
							res_col_q <= pv_q ? pc_q : '0;
						end
						default: begin
							res_status_q <= ST_OK;
							res_row_q <= in_row;
							res_col_q <= in_col;
						end
					endcase
				end
			end
			S_DIV: if (div_done) sh_q <= div_rem + 1'b1;
			S_SHIFT: begin
				sh_a_s1 <= FIW'(sh_q - 1'b1);
				if (sh_q < cnt_q) sh_q <= sh_q + 1'b1;
				res_row_q <= pr_q;
				res_col_q <= pc_q;
			end
			S_DIRCHK: begin
				mr_q <= pr_q;
				mc_q <= pc_q;
				if (gr_q != KIND_HOLE) res_status_q <= ST_REFUSED;
			end
			S_RDCHK: res_kind_q <= gr_q;
			S_DONE: begin
				if (load_out) begin
					out_q <= {4'd0, (cnt_q == '0) && !pv_q, cnt32[OUT_W-1:0], res_kind_q,
						rc32[5:0], rr32[5:0], res_status_q};
				end
			end
			default: ;
		endcase
	end

	mcrp_mod #(.DW(FCW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_rnd),
		.divisor  (cnt_q),
		.done     (div_done),
		.rem      (div_rem)
	);

endmodule
